@@ hdl/pev_pkg.sv @@
// shared types and constants of the postfix expression evaluator
package pev_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned SYM_W           = 8;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned DEF_STACK_DEPTH = 32;

  // iterations of the shift-add multiply and the restoring divide
  localparam int unsigned ALU_STEPS  = DATA_W;
  localparam int unsigned ALU_STEP_W = $clog2(ALU_STEPS);

  // expression characters
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

@@ hdl/pev_stream_if.sv @@
// valid/ready channels for expression characters and results

interface pev_sym_if import pev_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface pev_res_if import pev_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   value;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ hdl/pev_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module pev_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/pev_alu.sv @@
// iterative arithmetic unit: one shared adder for add, sub, multiply and divide
module pev_alu import pev_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIX
  } state_e;

  state_e                state_q, state_d;
  alu_op_e               op_q, op_d;
  logic [ALU_STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0]     acc_q, acc_d;
  logic [DATA_W-1:0]     x_q, x_d;
  logic [DATA_W-1:0]     y_q, y_d;
  logic                  neg_q, neg_d;
  logic                  done_q, done_d;
  logic [DATA_W-1:0]     res_q, res_d;

  logic [DATA_W:0]   add_p;
  logic [DATA_W:0]   add_y;
  logic              add_sub;
  logic [DATA_W+1:0] add_s;
  logic              take;

  // shared adder operand selection
  always_comb begin
    add_p   = {1'b0, x_q};
    add_y   = {1'b0, y_q};
    add_sub = 1'b0;
    unique case (op_q)
      ALU_ADD: begin
        add_p = {1'b0, x_q};
        add_y = {1'b0, y_q};
      end
      ALU_SUB: begin
        add_p   = {1'b0, x_q};
        add_y   = {1'b0, y_q};
        add_sub = 1'b1;
      end
      ALU_MUL: begin
        add_p = {1'b0, acc_q};
        add_y = y_q[0] ? {1'b0, x_q} : '0;
      end
      ALU_DIV: begin
        add_p   = {acc_q, x_q[DATA_W-1]};
        add_y   = {1'b0, y_q};
        add_sub = 1'b1;
      end
      default: begin
        add_p = {1'b0, x_q};
      end
    endcase
  end

  assign add_s = {1'b0, add_p} + {1'b0, (add_sub ? ~add_y : add_y)}
               + {{(DATA_W+1){1'b0}}, add_sub};
  // carry out of a subtraction means no borrow
  assign take  = add_s[DATA_W+1];

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    step_d  = step_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d   = req_i.op;
          acc_d  = '0;
          neg_d  = req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
          step_d = ((req_i.op == ALU_MUL) || (req_i.op == ALU_DIV))
                 ? ALU_STEP_W'(ALU_STEPS - 1) : '0;
          if (req_i.op == ALU_DIV) begin
            x_d = req_i.a[DATA_W-1] ? (DATA_W'(0) - req_i.a) : req_i.a;
            y_d = req_i.b[DATA_W-1] ? (DATA_W'(0) - req_i.b) : req_i.b;
          end else begin
            x_d = req_i.a;
            y_d = req_i.b;
          end
          state_d = A_RUN;
        end
      end
      A_RUN: begin
        unique case (op_q)
          ALU_MUL: begin
            acc_d = add_s[DATA_W-1:0];
            x_d   = {x_q[DATA_W-2:0], 1'b0};
            y_d   = {1'b0, y_q[DATA_W-1:1]};
          end
          ALU_DIV: begin
            acc_d = take ? add_s[DATA_W-1:0] : add_p[DATA_W-1:0];
            x_d   = {x_q[DATA_W-2:0], take};
          end
          default: begin
            acc_d = add_s[DATA_W-1:0];
          end
        endcase
        step_d = step_q - ALU_STEP_W'(1);
        if (step_q == '0) begin
          if (op_q == ALU_DIV) begin
            state_d = A_FIX;
          end else begin
            res_d   = add_s[DATA_W-1:0];
            done_d  = 1'b1;
            state_d = A_IDLE;
          end
        end
      end
      A_FIX: begin
        // quotient sign from operand signs, INT_MIN / -1 wraps here
        res_d   = neg_q ? (DATA_W'(0) - x_q) : x_q;
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    step_q <= step_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

@@ hdl/postfix_expression_evaluator_core.sv @@
// Postfix evaluator: a digit, an ignored character, an operator short of operands or
// any character after an error passes S_IDLE and S_DECODE; an operator also passes
// S_OPER and S_WAIT for the add, shift-add or restoring-divide loop of the unit,
// skipping the unit on a zero divisor. The last character then loads the output
// register in S_FINISH once the previous result has left it. Reset (rst_ni low,
// asynchronous) empties the stack and clears the error; stack memory is not cleared.
module postfix_expression_evaluator_core import pev_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pev_sym_if.sink   in_i,
  pev_res_if.source out_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPER,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [STATUS_W-1:0] err_q, err_d;
  logic                out_valid_q, out_valid_d;
  logic [SYM_W-1:0]    sym_q, sym_d;
  logic                last_q, last_d;
  logic [DATA_W-1:0]   tos_q, tos_d;
  logic [DATA_W-1:0]   out_value_q, out_value_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic              is_digit;
  logic              is_op;
  alu_op_e           op_sel;
  logic [3:0]        digit;
  logic [CntW-1:0]   cnt_m1;
  logic [CntW-1:0]   cnt_m2;
  logic              div_zero;
  state_e            end_state;
  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // character decode, the low nibble of '0'..'9' is the digit value
  assign is_digit = (sym_q >= CH_ZERO) && (sym_q <= CH_NINE);
  assign digit    = sym_q[3:0];

  always_comb begin
    is_op  = 1'b1;
    op_sel = ALU_ADD;
    unique case (sym_q)
      CH_PLUS:  op_sel = ALU_ADD;
      CH_MINUS: op_sel = ALU_SUB;
      CH_STAR:  op_sel = ALU_MUL;
      CH_SLASH: op_sel = ALU_DIV;
      default:  is_op  = 1'b0;
    endcase
  end

  assign cnt_m1    = count_q - CntW'(1);
  assign cnt_m2    = count_q - CntW'(2);
  assign div_zero  = (op_sel == ALU_DIV) && (tos_q == '0);
  assign end_state = last_q ? S_FINISH : S_IDLE;

  // top of stack lives in tos_q, entries below it in the ram
  assign ram_we = (state_q == S_DECODE) && (err_q == ST_OK) && is_digit
               && (count_q != CntW'(STACK_DEPTH)) && (count_q != '0);

  pev_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_m1[AddrW-1:0]),
    .wdata_i (tos_q),
    .raddr_i (cnt_m2[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // operand a comes from the ram, operand b is the top of stack
  assign alu_req.start = (state_q == S_OPER) && !div_zero;
  assign alu_req.op    = op_sel;
  assign alu_req.a     = ram_rdata;
  assign alu_req.b     = tos_q;

  pev_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q;
    sym_d        = sym_q;
    last_d       = last_q;
    tos_d        = tos_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    // result transaction leaves the output register
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          sym_d   = in_i.symbol;
          last_d  = in_i.last_symbol;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = end_state;
        if (err_q == ST_OK) begin
          if (is_digit) begin
            if (count_q == CntW'(STACK_DEPTH)) begin
              err_d = ST_OVERFLOW;
            end else begin
              tos_d   = DATA_W'(digit);
              count_d = count_q + CntW'(1);
            end
          end else if (is_op) begin
            if (count_q < CntW'(2)) begin
              err_d = ST_UNDERFLOW;
            end else begin
              state_d = S_OPER;
            end
          end
        end
      end
      S_OPER: begin
        if (div_zero) begin
          err_d   = ST_DIVZERO;
          state_d = end_state;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          tos_d   = alu_rsp.result;
          count_d = cnt_m1;
          state_d = end_state;
        end
      end
      S_FINISH: begin
        // wait until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (err_q != ST_OK) begin
            out_status_d = err_q;
          end else if (count_q == '0) begin
            out_status_d = ST_UNDERFLOW;
          end else if (count_q != CntW'(1)) begin
            out_status_d = ST_LEFTOVER;
          end else begin
            out_status_d = ST_OK;
            out_value_d  = tos_q;
          end
          count_d = '0;
          err_d   = ST_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    last_q       <= last_d;
    tos_q        <= tos_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

endmodule

@@ test/tb_top.sv @@
// testbench of the postfix evaluator core: a directed table, then random expressions checked by a stack predictor
module tb_top;
  import pev_pkg::*;

  localparam int unsigned STK_DEPTH    = DEF_STACK_DEPTH;
  localparam int unsigned ITEM_TARGET  = 1900;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned N_ROWS       = 40;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } eval_res_t;

  typedef struct packed {
    logic [SYM_W-1:0]    sym;
    logic                last;
    int unsigned         reps;
    logic                typed;
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } stim_row_t;

  // directed expressions; a repeated row sets last only on its final copy
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{CH_NINE,          1'b1, 1,  1'b1, 32'd9,          ST_OK},
    '{CH_ZERO,          1'b1, 1,  1'b1, 32'd0,          ST_OK},
    '{8'hFF,            1'b1, 1,  1'b1, 32'd0,          ST_UNDERFLOW},
    '{CH_PLUS,          1'b1, 1,  1'b1, 32'd0,          ST_UNDERFLOW},
    '{CH_NINE,          1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd5,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_MINUS,         1'b1, 1,  1'b1, 32'd4,          ST_OK},
    '{CH_ZERO + 8'd3,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd4,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_STAR,          1'b1, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd7,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd2,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_SLASH,         1'b1, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd5,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO,          1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_SLASH,         1'b1, 1,  1'b1, 32'd0,          ST_DIVZERO},
    '{CH_ZERO + 8'd1,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd2,   1'b1, 1,  1'b1, 32'd0,          ST_LEFTOVER},
    '{CH_PLUS,          1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd5,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd5,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_PLUS,          1'b1, 1,  1'b1, 32'd0,          ST_UNDERFLOW},
    '{CH_ZERO + 8'd4,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{8'h00,            1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd4,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{8'h80,            1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_PLUS,          1'b1, 1,  1'b1, 32'd8,          ST_OK},
    '{CH_ZERO,          1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_NINE,          1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_MINUS,         1'b1, 1,  1'b1, 32'hFFFF_FFF7,  ST_OK},
    '{CH_ZERO + 8'd2,   1'b0, 31, 1'b0, 32'd0,          ST_OK},
    '{CH_STAR,          1'b0, 30, 1'b0, 32'd0,          ST_OK},
    '{CH_ZERO,          1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_ZERO + 8'd1,   1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_MINUS,         1'b0, 1,  1'b0, 32'd0,          ST_OK},
    '{CH_SLASH,         1'b1, 1,  1'b1, 32'h8000_0000,  ST_OK},
    '{CH_ZERO + 8'd7,   1'b0, 33, 1'b0, 32'd0,          ST_OK},
    '{CH_PLUS,          1'b1, 1,  1'b1, 32'd0,          ST_OVERFLOW},
    '{CH_NINE,          1'b0, 32, 1'b0, 32'd0,          ST_OK},
    '{CH_PLUS,          1'b1, 31, 1'b1, 32'd288,        ST_OK}
  };

  logic clk_i;
  logic rst_ni;

  pev_sym_if sym_if ();
  pev_res_if res_if ();

  postfix_expression_evaluator_core #(
    .STACK_DEPTH(STK_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (sym_if),
    .out_o (res_if)
  );

  // predictor state
  logic [DATA_W-1:0]   stack_mem [STK_DEPTH];
  int unsigned         stack_cnt;
  logic [STATUS_W-1:0] expr_err;

  eval_res_t        pending_res [$];
  logic [SYM_W-1:0] expr_buf [$];
  int unsigned      active_items;
  int unsigned      results_seen;
  int unsigned      errors;
  int unsigned      quiet_cycles;
  bit               no_idle;
  bit               held_off;

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic bit is_meaningful(input logic [SYM_W-1:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic void push_operand(input logic [DATA_W-1:0] v);
    if (stack_cnt >= STK_DEPTH) begin
      expr_err = ST_OVERFLOW;
    end else begin
      stack_mem[stack_cnt] = v;
      stack_cnt++;
    end
  endfunction

  // advance the evaluator by one character; returns 1 when a result is due
  function automatic bit eval_symbol(input logic [SYM_W-1:0] sym, input logic last,
                                     output eval_res_t res);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    longint            quot;
    res = '0;
    if (expr_err == ST_OK) begin
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
        push_operand(DATA_W'(sym - CH_ZERO));
      end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH) begin
        if (stack_cnt < 2) begin
          expr_err = ST_UNDERFLOW;
        end else begin
          rhs = stack_mem[stack_cnt-1];
          lhs = stack_mem[stack_cnt-2];
          stack_cnt -= 2;
          case (sym)
            CH_PLUS:  push_operand(lhs + rhs);
            CH_MINUS: push_operand(lhs - rhs);
            CH_STAR:  push_operand(lhs * rhs);
            default: begin
              if (rhs == '0) begin
                expr_err = ST_DIVZERO;
              end else begin
                // 64-bit quotient so that the most negative value over -1 just wraps
                quot = longint'($signed(lhs)) / longint'($signed(rhs));
                push_operand(quot[DATA_W-1:0]);
              end
            end
          endcase
        end
      end
    end
    if (!last) return 1'b0;
    res.status = expr_err;
    if (expr_err == ST_OK) begin
      if (stack_cnt == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.value = stack_mem[stack_cnt-1];
        stack_cnt--;
        if (stack_cnt != 0) res.status = ST_LEFTOVER;
      end
    end
    if (res.status != ST_OK) res.value = '0;
    stack_cnt = 0;
    expr_err  = ST_OK;
    return 1'b1;
  endfunction

  function automatic logic [SYM_W-1:0] pick_digit();
    return CH_ZERO + SYM_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [SYM_W-1:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] pick_ignored();
    logic [SYM_W-1:0] c;
    do c = SYM_W'($urandom_range(0, 255)); while (is_meaningful(c));
    return c;
  endfunction

  // valid postfix expression with n_ops operators, stray characters mixed in
  function automatic void add_well_formed(input int unsigned n_ops, input bit operands_first);
    int unsigned pushes_left;
    int unsigned ops_left;
    int unsigned depth;
    pushes_left = n_ops + 1;
    ops_left    = n_ops;
    depth       = 0;
    while (pushes_left + ops_left > 0) begin
      if ($urandom_range(0, 9) == 0) expr_buf.push_back(pick_ignored());
      if (pushes_left > 0 && (depth < 2 || operands_first || $urandom_range(0, 1) == 1)) begin
        expr_buf.push_back(pick_digit());
        pushes_left--;
        depth++;
      end else begin
        expr_buf.push_back(pick_op());
        ops_left--;
        depth--;
      end
    end
  endfunction

  // offer one character and wait for the transaction
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last,
                             input logic typed, input eval_res_t typed_res);
    eval_res_t pred;
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      sym_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    sym_if.valid       <= 1'b1;
    sym_if.symbol      <= sym;
    sym_if.last_symbol <= last;
    do @(posedge clk_i); while (!sym_if.ready);
    if (eval_symbol(sym, last, pred)) pending_res.push_back(typed ? typed_res : pred);
    active_items++;
    @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    eval_res_t   row_res;
    int unsigned kind;
    int unsigned n_ops;
    bit          deep;
    rst_ni             = 1'b0;
    sym_if.valid       = 1'b0;
    sym_if.symbol      = '0;
    sym_if.last_symbol = 1'b0;
    stack_cnt          = 0;
    expr_err           = ST_OK;
    active_items       = 0;
    no_idle            = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (DIRECTED[r]) begin
      row_res.value  = DIRECTED[r].value;
      row_res.status = DIRECTED[r].status;
      for (int unsigned k = 0; k < DIRECTED[r].reps; k++) begin
        send_symbol(DIRECTED[r].sym, DIRECTED[r].last && (k == DIRECTED[r].reps - 1),
                    DIRECTED[r].typed, row_res);
      end
    end

    // random expressions, mostly well formed
    while (active_items < ITEM_TARGET) begin
      no_idle = (active_items >= 800 && active_items < 1100);
      expr_buf.delete();
      kind  = $urandom_range(0, 99);
      n_ops = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 19) : $urandom_range(0, 5);
      deep  = ($urandom_range(0, 3) == 0);
      if (kind < 70) begin
        add_well_formed(n_ops, deep);
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 3)) expr_buf.push_back(pick_digit());
        add_well_formed(n_ops, deep);
      end else if (kind < 86) begin
        if ($urandom_range(0, 1) == 1) expr_buf.push_back(pick_op());
        add_well_formed(n_ops, deep);
        expr_buf.push_back(pick_op());
      end else if (kind < 90) begin
        repeat ($urandom_range(STK_DEPTH + 1, STK_DEPTH + 4)) expr_buf.push_back(pick_digit());
        repeat ($urandom_range(0, 3)) expr_buf.push_back(pick_op());
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1) == 1) expr_buf.push_back(SYM_W'($urandom_range(0, 255)));
          else if ($urandom_range(0, 1) == 1) expr_buf.push_back(pick_digit());
          else expr_buf.push_back(pick_op());
        end
      end
      if ($urandom_range(0, 9) == 0) expr_buf.push_back(pick_ignored());
      foreach (expr_buf[i]) send_symbol(expr_buf[i], i == expr_buf.size() - 1, 1'b0, '0);
    end
    sym_if.valid <= 1'b0;

    // drain
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // result sink: random stalls, one long hold-off so the core backs up
  initial begin
    res_if.ready = 1'b0;
    held_off     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_seen >= 40) begin
        held_off = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      res_if.ready <= no_idle || ($urandom_range(0, 99) >= 33);
    end
  end

  // result check against the oldest expectation
  initial begin
    errors       = 0;
    results_seen = 0;
  end

  always @(posedge clk_i) begin
    eval_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        $error("result transaction with none expected: value %0d status %0d",
               $signed(res_if.value), res_if.status);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (res_if.value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(res_if.value));
          errors++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
